### src/assert_macros.svh
// Assertion macros used by the ordered list engine RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every clock edge outside reset.
`define OLE_ASSERT(lbl, clk_s, rstn_s, prop) \
    lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (prop)) \
        else $error("ordered list engine check failed");

// Check that an antecedent implies a consequent in the following cycle.
`define OLE_ASSERT_NEXT(lbl, clk_s, rstn_s, ante, cons) \
    lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |=> (cons)) \
        else $error("ordered list engine sequencing check failed");

`endif

### src/ole_pkg.sv
// Types and constants of the ordered list engine.
`default_nettype none

package ole_pkg;

    localparam int DATA_W   = 32;
    localparam int ACTION_W = 3;
    localparam int STATUS_W = 2;
    localparam int COUNT_W  = 5;

    typedef enum logic [ACTION_W-1:0] {
        ACT_ADD_HEAD  = 3'd0,
        ACT_ADD_TAIL  = 3'd1,
        ACT_REM_HEAD  = 3'd2,
        ACT_REM_TAIL  = 3'd3,
        ACT_REM_VALUE = 3'd4,
        ACT_CONTAINS  = 3'd5
    } action_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK     = 2'd0,
        ST_EMPTY  = 2'd1,
        ST_FULL   = 2'd2,
        ST_ABSENT = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        PH_IDLE  = 2'd0,
        PH_SCAN  = 2'd1,
        PH_APPLY = 2'd2
    } phase_t;

    // Broadcast from the sequencer to every cell of the row.
    typedef struct packed {
        logic                     scan;
        logic                     apply;
        action_t                  action;
        logic signed [DATA_W-1:0] value;
    } cell_ctrl_t;

endpackage

`default_nettype wire

### src/ole_cell.sv
// One storage cell of the list row: element, match flag and neighbor shifting.
`default_nettype none

module ole_cell (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire ole_pkg::cell_ctrl_t              ctrl,
    input  wire logic                             occupied,
    input  wire logic                             tail_slot,
    input  wire logic                             last_slot,
    input  wire logic signed [ole_pkg::DATA_W-1:0] left_data,
    input  wire logic signed [ole_pkg::DATA_W-1:0] right_data,
    input  wire logic                             hit_in,
    output logic signed [ole_pkg::DATA_W-1:0]      data,
    output logic                                  hit_out,
    output logic signed [ole_pkg::DATA_W-1:0]      tail_word
);
    import ole_pkg::*;

    logic signed [DATA_W-1:0] data_reg;
    logic signed [DATA_W-1:0] data_next;
    logic signed [DATA_W-1:0] tail_word_reg;
    logic signed [DATA_W-1:0] tail_word_next;
    logic                     match_reg;
    logic                     match_next;

    // A cell at or past the first match takes its right neighbor on remove value.
    assign hit_out = hit_in | match_reg;

    always_comb
    begin
        data_next = data_reg;
        if (ctrl.apply)
        begin
            unique case (ctrl.action)
                ACT_ADD_HEAD:  data_next = left_data;
                ACT_ADD_TAIL:
                begin
                    if (tail_slot)
                    begin
                        data_next = ctrl.value;
                    end
                end
                ACT_REM_HEAD:  data_next = right_data;
                ACT_REM_VALUE:
                begin
                    if (hit_out)
                    begin
                        data_next = right_data;
                    end
                end
                default:       data_next = data_reg;
            endcase
        end
    end

    always_comb
    begin
        match_next     = match_reg;
        tail_word_next = tail_word_reg;
        if (ctrl.scan)
        begin
            match_next     = occupied && (data_reg == ctrl.value);
            tail_word_next = last_slot ? data_reg : '0;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg      <= data_next;
        tail_word_reg <= tail_word_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            match_reg <= 1'b0;
        end
        else
        begin
            match_reg <= match_next;
        end
    end

    assign data      = data_reg;
    assign tail_word = tail_word_reg;

endmodule

`default_nettype wire

### src/ordered_list_engine.sv
// Ordered list engine: each request goes through its steps in order: accept, compare the
// value in every cell of the row, then shift the row and write the result register. in_stall
// stays high until the current request is done, so a new request is accepted only then.
// A waiting result does not block acceptance and compare of the next request.
// Reset clears the element count, the sequencer and the output valid;
// element storage is not cleared and is read only below the count.
`default_nettype none

`include "assert_macros.svh"

module ordered_list_engine #(
    parameter int CAPACITY = 16
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               in_valid,
    output logic                                    in_stall,
    input  wire logic [ole_pkg::ACTION_W-1:0]       action,
    input  wire logic signed [ole_pkg::DATA_W-1:0]  value,
    output logic                                    out_valid,
    input  wire logic                               out_stall,
    output logic signed [ole_pkg::DATA_W-1:0]       removed_value,
    output logic                                    found,
    output logic [ole_pkg::STATUS_W-1:0]            status,
    output logic [ole_pkg::COUNT_W-1:0]             count
);
    import ole_pkg::*;

    localparam int CW = $clog2(CAPACITY + 1);

    phase_t                   phase_reg;
    phase_t                   phase_next;
    action_t                  action_reg;
    action_t                  action_next;
    logic signed [DATA_W-1:0] value_reg;
    logic signed [DATA_W-1:0] value_next;
    logic [CW-1:0]            count_reg;
    logic [CW-1:0]            count_next;

    logic                     out_valid_reg;
    logic                     out_valid_next;
    logic signed [DATA_W-1:0] removed_reg;
    logic signed [DATA_W-1:0] removed_next;
    logic                     found_reg;
    logic                     found_next;
    status_t                  status_reg;
    status_t                  status_next;

    cell_ctrl_t               ctrl;
    logic                     fire;
    logic                     modify;
    logic                     empty;
    logic                     full;
    logic signed [DATA_W-1:0] tail_value;
    logic signed [DATA_W-1:0] res_removed;
    logic                     res_found;
    status_t                  res_status;
    logic [CW-1:0]            res_count;

    logic signed [DATA_W-1:0] cell_data [CAPACITY];
    logic signed [DATA_W-1:0] cell_tail [CAPACITY];
    logic [CAPACITY:0]        hit_chain;

    assign hit_chain[0] = 1'b0;
    assign empty        = (count_reg == '0);
    assign full         = (count_reg == CW'(CAPACITY));

    genvar gi;
    generate
        for (gi = 0; gi < CAPACITY; gi++)
        begin : g_cell
            logic signed [DATA_W-1:0] left_w;
            logic signed [DATA_W-1:0] right_w;

            if (gi == 0)
            begin : g_head
                assign left_w = ctrl.value;
            end
            else
            begin : g_body
                assign left_w = cell_data[gi-1];
            end

            if (gi == CAPACITY - 1)
            begin : g_end
                assign right_w = cell_data[gi];
            end
            else
            begin : g_mid
                assign right_w = cell_data[gi+1];
            end

            ole_cell u_cell (
                .clk        (clk),
                .rst_n      (rst_n),
                .ctrl       (ctrl),
                .occupied   (count_reg > CW'(gi)),
                .tail_slot  (count_reg == CW'(gi)),
                .last_slot  (count_reg == CW'(gi + 1)),
                .left_data  (left_w),
                .right_data (right_w),
                .hit_in     (hit_chain[gi]),
                .data       (cell_data[gi]),
                .hit_out    (hit_chain[gi+1]),
                .tail_word  (cell_tail[gi])
            );
        end
    endgenerate

    // Only the last occupied cell drives a nonzero tail word.
    always_comb
    begin
        tail_value = '0;
        for (int i = 0; i < CAPACITY; i++)
        begin
            tail_value = tail_value | cell_tail[i];
        end
    end

    // Resolve the request against the row.
    always_comb
    begin
        res_removed = '0;
        res_found   = 1'b0;
        res_status  = ST_OK;
        res_count   = count_reg;
        modify      = 1'b0;
        unique case (action_reg)
            ACT_ADD_HEAD, ACT_ADD_TAIL:
            begin
                if (full)
                begin
                    res_status = ST_FULL;
                end
                else
                begin
                    modify    = 1'b1;
                    res_count = count_reg + CW'(1);
                end
            end
            ACT_REM_HEAD, ACT_REM_TAIL:
            begin
                if (empty)
                begin
                    res_status = ST_EMPTY;
                end
                else
                begin
                    modify      = 1'b1;
                    res_count   = count_reg - CW'(1);
                    res_removed = (action_reg == ACT_REM_HEAD) ? cell_data[0] : tail_value;
                end
            end
            ACT_REM_VALUE, ACT_CONTAINS:
            begin
                if (empty)
                begin
                    res_status = ST_EMPTY;
                end
                else if (hit_chain[CAPACITY])
                begin
                    res_found = 1'b1;
                    if (action_reg == ACT_REM_VALUE)
                    begin
                        modify    = 1'b1;
                        res_count = count_reg - CW'(1);
                    end
                end
                else
                begin
                    res_status = ST_ABSENT;
                end
            end
            default:
            begin
                res_status = ST_OK;
            end
        endcase
    end

    // Hold the apply step while the previous result still waits.
    assign fire = (phase_reg == PH_APPLY) && !(out_valid_reg && out_stall);

    always_comb
    begin
        ctrl.scan   = (phase_reg == PH_SCAN);
        ctrl.apply  = fire && modify;
        ctrl.action = action_reg;
        ctrl.value  = value_reg;
    end

    always_comb
    begin
        phase_next     = phase_reg;
        action_next    = action_reg;
        value_next     = value_reg;
        count_next     = count_reg;
        removed_next   = removed_reg;
        found_next     = found_reg;
        status_next    = status_reg;
        out_valid_next = out_valid_reg && out_stall;
        in_stall       = (phase_reg != PH_IDLE);
        unique case (phase_reg)
            PH_IDLE:
            begin
                if (in_valid)
                begin
                    action_next = action_t'(action);
                    value_next  = value;
                    phase_next  = PH_SCAN;
                end
            end
            PH_SCAN:
            begin
                phase_next = PH_APPLY;
            end
            PH_APPLY:
            begin
                if (fire)
                begin
                    count_next     = res_count;
                    removed_next   = res_removed;
                    found_next     = res_found;
                    status_next    = res_status;
                    out_valid_next = 1'b1;
                    phase_next     = PH_IDLE;
                end
            end
            default:
            begin
                phase_next = PH_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_IDLE;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            phase_reg     <= phase_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        action_reg  <= action_next;
        value_reg   <= value_next;
        removed_reg <= removed_next;
        found_reg   <= found_next;
        status_reg  <= status_next;
    end

    assign out_valid     = out_valid_reg;
    assign removed_value = removed_reg;
    assign found         = found_reg;
    assign status        = status_reg;
    assign count         = COUNT_W'(count_reg);

    `OLE_ASSERT(a_count_in_range, clk, rst_n, count_reg <= CW'(CAPACITY))
    `OLE_ASSERT_NEXT(a_accept_to_scan, clk, rst_n, in_valid && !in_stall, phase_reg == PH_SCAN)
    `OLE_ASSERT(a_found_is_ok, clk, rst_n, !(out_valid_reg && found_reg) || status_reg == ST_OK)
    `OLE_ASSERT(a_full_means_full, clk, rst_n,
        !(out_valid_reg && status_reg == ST_FULL) || count_reg == CW'(CAPACITY))
    `OLE_ASSERT_NEXT(a_count_moves_on_fire, clk, rst_n, !fire, count_reg == $past(count_reg))

endmodule

`default_nettype wire

### verif/ordered_list_engine_test.sv
// Self-checking testbench of the ordered list engine: random and directed requests.
module ordered_list_engine_test;
    timeunit 1ns;
    timeprecision 1ps;

    import ole_pkg::*;

    localparam int CAPACITY   = 16;
    localparam int RANDOM_REQS = 750;
    localparam int MAX_WAIT   = 18;
    localparam int POOL_SIZE  = 8;

    // Action codes the block leaves unused
    localparam logic [ACTION_W-1:0] ACT_SPARE_LO = 3'd6;
    localparam logic [ACTION_W-1:0] ACT_SPARE_HI = 3'd7;

    typedef enum int {
        MIX_GROW,
        MIX_SHRINK,
        MIX_SEARCH
    } mix_t;

    typedef struct {
        logic [ACTION_W-1:0]      action;
        logic signed [DATA_W-1:0] value;
        bit                       drain_first;
    } list_req_t;

    typedef struct {
        logic signed [DATA_W-1:0] removed_value;
        logic                     found;
        status_t                  status;
        logic [COUNT_W-1:0]       count;
    } list_result_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_stall;
    logic [ACTION_W-1:0] action = '0;
    logic signed [DATA_W-1:0] value = '0;
    logic out_valid;
    logic out_stall = 1'b0;
    logic signed [DATA_W-1:0] removed_value;
    logic found;
    logic [STATUS_W-1:0] status;
    logic [COUNT_W-1:0] count;

    list_req_t pending_reqs[$];
    list_result_t expected_results[$];
    logic signed [DATA_W-1:0] held_elems[$];
    logic signed [DATA_W-1:0] value_pool[POOL_SIZE];
    list_req_t cur_req;
    int errors = 0;
    int send_gap = 0;
    int stall_left = 0;
    bit send_burst = 1'b0;
    bit recv_burst = 1'b0;

    ordered_list_engine #(
        .CAPACITY(CAPACITY)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .action(action),
        .value(value),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .removed_value(removed_value),
        .found(found),
        .status(status),
        .count(count)
    );

    always #5 clk = ~clk;

    initial
    begin
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
    end

    initial
    begin
        #5_000_000;
        $display("simulation failed");
        $finish;
    end

    // Apply one request to the shadow list and return what the block should report.
    function automatic list_result_t apply_to_list(input list_req_t r);
        list_result_t res;
        int pos;
        res.removed_value = '0;
        res.found = 1'b0;
        res.status = ST_OK;
        pos = -1;
        case (r.action)
            ACT_ADD_HEAD, ACT_ADD_TAIL:
            begin
                if (held_elems.size() >= CAPACITY)
                    res.status = ST_FULL;
                else if (r.action == ACT_ADD_HEAD)
                    held_elems.push_front(r.value);
                else
                    held_elems.push_back(r.value);
            end
            ACT_REM_HEAD, ACT_REM_TAIL:
            begin
                if (held_elems.size() == 0)
                    res.status = ST_EMPTY;
                else if (r.action == ACT_REM_HEAD)
                    res.removed_value = held_elems.pop_front();
                else
                    res.removed_value = held_elems.pop_back();
            end
            ACT_REM_VALUE, ACT_CONTAINS:
            begin
                if (held_elems.size() == 0)
                    res.status = ST_EMPTY;
                else
                begin
                    for (int i = 0; i < held_elems.size(); i++)
                    begin
                        if (pos < 0 && held_elems[i] == r.value)
                            pos = i;
                    end
                    if (pos < 0)
                        res.status = ST_ABSENT;
                    else
                    begin
                        res.found = 1'b1;
                        if (r.action == ACT_REM_VALUE)
                            held_elems.delete(pos);
                    end
                end
            end
            default:
                ;
        endcase
        res.count = COUNT_W'(held_elems.size());
        return res;
    endfunction

    task automatic queue_req(input logic [ACTION_W-1:0] act, input logic signed [DATA_W-1:0] v,
                             input bit drain = 1'b0);
        list_req_t r;
        r.action = act;
        r.value = v;
        r.drain_first = drain;
        pending_reqs.push_back(r);
    endtask

    function automatic logic signed [DATA_W-1:0] pick_value();
        int roll;
        roll = $urandom_range(0, 9);
        if (roll < 6)
            return value_pool[$urandom_range(0, POOL_SIZE - 1)];
        return $urandom();
    endfunction

    function automatic logic [ACTION_W-1:0] pick_action(input mix_t mix);
        int roll;
        roll = $urandom_range(0, 99);
        if (roll >= 98)
            return $urandom_range(0, 1) ? ACT_SPARE_HI : ACT_SPARE_LO;
        case (mix)
            MIX_GROW:
            begin
                if (roll < 38) return ACT_ADD_HEAD;
                if (roll < 74) return ACT_ADD_TAIL;
                if (roll < 82) return ACT_REM_VALUE;
                if (roll < 90) return ACT_CONTAINS;
                if (roll < 94) return ACT_REM_HEAD;
                return ACT_REM_TAIL;
            end
            MIX_SHRINK:
            begin
                if (roll < 8) return ACT_ADD_HEAD;
                if (roll < 16) return ACT_ADD_TAIL;
                if (roll < 40) return ACT_REM_VALUE;
                if (roll < 50) return ACT_CONTAINS;
                if (roll < 74) return ACT_REM_HEAD;
                return ACT_REM_TAIL;
            end
            default:
            begin
                if (roll < 15) return ACT_ADD_HEAD;
                if (roll < 30) return ACT_ADD_TAIL;
                if (roll < 55) return ACT_REM_VALUE;
                if (roll < 80) return ACT_CONTAINS;
                if (roll < 89) return ACT_REM_HEAD;
                return ACT_REM_TAIL;
            end
        endcase
    endfunction

    task automatic compare_field(input string name, input longint exp_v, input longint got_v);
        if (exp_v != got_v)
        begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp_v, got_v);
            errors++;
        end
    endtask

    // Driver: present the next pending request once its gap has run out and, if it must drain first, no result waits
    always @(posedge clk)
    begin : driver
        bit launch;
        launch = 1'b0;
        if (rst_n && !(in_valid && in_stall))
        begin
            if (in_valid)
                expected_results.push_back(apply_to_list(cur_req));
            if (pending_reqs.size() != 0)
            begin
                if (send_gap != 0)
                    send_gap--;
                else if (!(pending_reqs[0].drain_first && expected_results.size() != 0))
                    launch = 1'b1;
            end
            if (launch)
            begin
                cur_req = pending_reqs.pop_front();
                in_valid <= 1'b1;
                action <= cur_req.action;
                value <= cur_req.value;
                if ($urandom_range(0, 24) == 0)
                    send_burst = !send_burst;
                send_gap = send_burst ? 0 : $urandom_range(0, MAX_WAIT);
            end
            else
                in_valid <= 1'b0;
        end
    end

    // Monitor: check each result and draw the stall before the next one
    always @(posedge clk)
    begin : monitor
        list_result_t exp_res;
        if (rst_n)
        begin
            if (out_valid && !out_stall)
            begin
                if (expected_results.size() == 0)
                begin
                    $display("%0t: unexpected result, removed %0d found %0d status %0d count %0d",
                             $time, removed_value, found, status, count);
                    errors++;
                end
                else
                begin
                    exp_res = expected_results.pop_front();
                    compare_field("removed_value", exp_res.removed_value, removed_value);
                    compare_field("found", exp_res.found, found);
                    compare_field("status", exp_res.status, status);
                    compare_field("count", exp_res.count, count);
                end
                if ($urandom_range(0, 24) == 0)
                    recv_burst = !recv_burst;
                stall_left = recv_burst ? 0 : $urandom_range(0, MAX_WAIT);
            end
            if (stall_left != 0)
            begin
                stall_left--;
                out_stall <= 1'b1;
            end
            else
                out_stall <= 1'b0;
        end
    end

    initial
    begin
        int made;
        int len;
        mix_t mix;
        logic [ACTION_W-1:0] act;

        value_pool[0] = 32'sh0000_0000;
        value_pool[1] = -32'sd1;
        value_pool[2] = 32'sh7fff_ffff;
        value_pool[3] = 32'sh8000_0000;
        for (int i = 4; i < POOL_SIZE; i++)
            value_pool[i] = $urandom();

        // Removals and searches on an empty list
        queue_req(ACT_REM_HEAD, 32'sd5);
        queue_req(ACT_REM_TAIL, 32'sd5);
        queue_req(ACT_REM_VALUE, 32'sd0);
        queue_req(ACT_CONTAINS, 32'sd0);
        // Extremes at both ends, then a duplicate
        queue_req(ACT_ADD_HEAD, 32'sh7fff_ffff);
        queue_req(ACT_ADD_TAIL, 32'sh8000_0000);
        queue_req(ACT_ADD_TAIL, -32'sd1);
        queue_req(ACT_ADD_HEAD, 32'sh0000_0000);
        queue_req(ACT_ADD_TAIL, -32'sd1);
        queue_req(ACT_ADD_HEAD, 32'sh5555_5555);
        // Only the copy nearest the head goes
        queue_req(ACT_REM_VALUE, -32'sd1);
        queue_req(ACT_CONTAINS, -32'sd1);
        queue_req(ACT_CONTAINS, 32'sh2aaa_aaaa);
        queue_req(ACT_REM_VALUE, 32'sh2aaa_aaaa);
        queue_req(ACT_SPARE_LO, 32'sh1234_5678);
        queue_req(ACT_SPARE_HI, -32'sd1);
        queue_req(ACT_REM_HEAD, 32'sd0);
        queue_req(ACT_REM_TAIL, 32'sd0);

        // Fill past capacity, then empty past zero
        for (int i = 0; i < CAPACITY + 2; i++)
            queue_req(i[0] ? ACT_ADD_HEAD : ACT_ADD_TAIL, pick_value(), i == 0);
        for (int i = 0; i < CAPACITY + 2; i++)
            queue_req(i[0] ? ACT_REM_TAIL : ACT_REM_HEAD, pick_value());
        made = 2 * (CAPACITY + 2);

        while (made < RANDOM_REQS)
        begin
            mix = mix_t'($urandom_range(0, 2));
            len = $urandom_range(10, 40);
            for (int i = 0; i < len; i++)
            begin
                act = pick_action(mix);
                queue_req(act, pick_value(), $urandom_range(0, 99) == 0);
                if (act != ACT_SPARE_LO && act != ACT_SPARE_HI)
                    made++;
            end
        end

        while (rst_n !== 1'b1 || pending_reqs.size() != 0 || in_valid
               || expected_results.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
        if (errors == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

### filelist.f
+incdir+src
src/ole_pkg.sv
src/ole_cell.sv
src/ordered_list_engine.sv
verif/ordered_list_engine_test.sv
